// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the substring match finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a property holds at every rising clock edge outside reset.
`define SMF_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds at a rising clock edge outside reset.
`define SMF_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SMF_ASSERT(name, clk, rst_n, prop, msg)
`define SMF_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/smf_pkg.sv
// Package with sizes and the control bundle of the substring match finder.
`timescale 1ns / 1ps
package smf_pkg;

    // Longest pattern and longest text that the block handles.
    localparam int PATTERN_MAX = 64;
    localparam int TEXT_MAX    = 1024;

    // Derived widths.
    localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam int POS_W   = $clog2(TEXT_MAX + 1);
    localparam int MATCH_W = 10;
    localparam int DIFF_W0 = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int DIFF_W  = (DIFF_W0 > MATCH_W) ? DIFF_W0 : MATCH_W;

    // Request kinds.
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    typedef logic [7:0] byte_t;

    // Broadcast control from the sequencer to every cell of the chain.
    typedef struct packed {
        logic             text_shift;
        logic             text_clear;
        logic             load_shift;
        logic             pat_write;
        logic             pat_commit;
        logic [LEN_W-1:0] pat_target;
        logic [LEN_W-1:0] length;
        byte_t            data;
    } smf_cell_ctrl_t;

endpackage

// File: rtl/smf_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
interface smf_req_if;
    import smf_pkg::*;
    logic  valid;
    logic  ready;
    logic  req_type;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output req_type, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input req_type, input data_byte, input last_byte,
                    output ready);
endinterface

interface smf_res_if;
    import smf_pkg::*;
    logic               valid;
    logic               ready;
    logic [MATCH_W-1:0] match_position;

    modport source (output valid, output match_position, input ready);
    modport sink   (input valid, input match_position, output ready);
endinterface

// File: rtl/smf_cell.sv
// One cell of the match chain: a text window byte, a load byte and an aligned pattern byte.
`timescale 1ns / 1ps
module smf_cell
    import smf_pkg::*;
(
    input  logic           clk,
    input  smf_cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0] cell_idx,
    input  byte_t          win_in,
    input  byte_t          ld_in,
    output byte_t          win_out,
    output byte_t          ld_out,
    output logic           hit
);

    byte_t win_reg;
    byte_t ld_reg;
    byte_t pat_reg;
    byte_t ld_next;
    logic  idle_cell;

    // The cell lies beyond the pattern when its age index reaches the length.
    assign idle_cell = (LEN_W'(cell_idx) >= ctrl.length);

    // Compare the byte that enters this cell against the aligned pattern byte.
    assign hit = idle_cell || (win_in == pat_reg);

    assign ld_next = ctrl.load_shift ? ld_in : ld_reg;

    // Text window: shifts toward older entries, clears at the end of a text.
    always_ff @(posedge clk)
    begin
        if (ctrl.text_clear)
        begin
            win_reg <= '0;
        end
        else if (ctrl.text_shift)
        begin
            win_reg <= win_in;
        end
    end

    // Load chain: collects a new pattern newest first.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_shift)
        begin
            ld_reg <= ld_in;
        end
    end

    // Aligned pattern byte: replaced on commit, patched while a reload runs.
    always_ff @(posedge clk)
    begin
        if (ctrl.pat_commit)
        begin
            pat_reg <= ld_next;
        end
        else if (ctrl.pat_write && (ctrl.pat_target == LEN_W'(cell_idx)))
        begin
            pat_reg <= ctrl.data;
        end
    end

    assign win_out = win_reg;
    assign ld_out  = ld_reg;

endmodule

// File: rtl/substring_match_finder.sv
// Top level of the substring match finder: sequencer, cell chain and result register.
//
// Usage: requests arrive on req_chan. A request with req_type 0 loads the next
// pattern byte; the one marked last_byte fixes the pattern length (up to
// PATTERN_MAX bytes, longer patterns are cut). A request with req_type 1 feeds
// one text byte; last_byte ends the text and returns the position to zero.
// Whenever the newest pattern-length text bytes equal the pattern, one result
// carrying the zero-based start index goes out on match_chan.
// Throughput is one request per cycle while the receiver takes results: every
// cell compares the byte entering it with its pattern byte in the same cycle,
// and the hit bits are combined before the result register, which shows a
// match the cycle after its text byte. Text bytes past TEXT_MAX are ignored.
// When the receiver stalls, the result register holds the match and req_chan
// takes no further request until it is taken. Reset empties the result
// register and clears pattern length, load index and text position.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module substring_match_finder
    import smf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    smf_req_if.sink   req_chan,
    smf_res_if.source match_chan
);

    logic [LEN_W-1:0]   length_reg;
    logic [LEN_W-1:0]   load_idx_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               out_valid_reg;
    logic [MATCH_W-1:0] out_pos_reg;

    logic               accept;
    logic               load_acc;
    logic               text_acc;
    logic               load_room;
    logic               text_room;
    logic [LEN_W-1:0]   load_idx_next;
    logic [POS_W-1:0]   pos_next;
    logic [DIFF_W-1:0]  start_diff;
    logic               match;
    smf_cell_ctrl_t     ctrl;

    byte_t              win_chain [PATTERN_MAX+1];
    byte_t              ld_chain  [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] hit_vec;

    // Handshake: a new request is taken whenever the result slot is free.
    assign req_chan.ready = !out_valid_reg || match_chan.ready;
    assign accept   = req_chan.valid && req_chan.ready;
    assign load_acc = accept && (req_chan.req_type == REQ_PATTERN);
    assign text_acc = accept && (req_chan.req_type == REQ_TEXT);

    assign load_room = (load_idx_reg < LEN_W'(PATTERN_MAX));
    assign text_room = (pos_reg < POS_W'(TEXT_MAX));
    assign load_idx_next = load_room ? (load_idx_reg + LEN_W'(1)) : load_idx_reg;
    assign pos_next = pos_reg + POS_W'(1);

    // Control broadcast to the chain.
    always_comb
    begin
        ctrl.text_shift = text_acc && text_room;
        ctrl.text_clear = text_acc && req_chan.last_byte;
        ctrl.load_shift = load_acc && load_room;
        ctrl.pat_write  = load_acc && (load_idx_reg < length_reg);
        ctrl.pat_commit = load_acc && req_chan.last_byte;
        ctrl.pat_target = length_reg - LEN_W'(1) - load_idx_reg;
        ctrl.length     = length_reg;
        ctrl.data       = req_chan.data_byte;
    end

    // Chain of cells; cell 0 holds the newest text byte.
    assign win_chain[0] = req_chan.data_byte;
    assign ld_chain[0]  = req_chan.data_byte;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        smf_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .cell_idx (IDX_W'(g)),
            .win_in   (win_chain[g]),
            .ld_in    (ld_chain[g]),
            .win_out  (win_chain[g+1]),
            .ld_out   (ld_chain[g+1]),
            .hit      (hit_vec[g])
        );
    end

    // A match needs a nonempty pattern, enough text and every cell agreeing.
    assign match = ctrl.text_shift && (length_reg != '0)
                   && (DIFF_W'(pos_next) >= DIFF_W'(length_reg)) && (&hit_vec);
    assign start_diff = DIFF_W'(pos_next) - DIFF_W'(length_reg);

    // Pattern load bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            load_idx_reg <= '0;
        end
        else if (load_acc)
        begin
            if (req_chan.last_byte)
            begin
                length_reg   <= load_idx_next;
                load_idx_reg <= '0;
            end
            else
            begin
                load_idx_reg <= load_idx_next;
            end
        end
    end

    // Text position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (text_acc)
        begin
            if (req_chan.last_byte)
            begin
                pos_reg <= '0;
            end
            else if (text_room)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= match;
        end
        else if (match_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && match)
        begin
            out_pos_reg <= start_diff[MATCH_W-1:0];
        end
    end

    assign match_chan.valid          = out_valid_reg;
    assign match_chan.match_position = out_pos_reg;

    // Checks on the sequencer state.
    `SMF_ASSERT(a_load_idx_range, clk, rst_n, load_idx_reg <= LEN_W'(PATTERN_MAX), "load index out of range")
    `SMF_ASSERT(a_length_range, clk, rst_n, length_reg <= LEN_W'(PATTERN_MAX), "pattern length out of range")
    `SMF_ASSERT(a_pos_range, clk, rst_n, pos_reg <= POS_W'(TEXT_MAX), "text position out of range")
    `SMF_ASSERT(a_text_end, clk, rst_n, (text_acc && req_chan.last_byte) |=> (pos_reg == '0), "text end did not clear position")
    `SMF_NEVER(a_load_no_result, clk, rst_n, load_acc && match, "pattern request produced a match")

endmodule
